// ===== sv/dual_output_fault_protector_defines.svh =====
// assertion macros for the dual output fault protector
`ifndef DUAL_OUTPUT_FAULT_PROTECTOR_DEFINES_SVH
`define DUAL_OUTPUT_FAULT_PROTECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DOFP_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("dofp check failed");

// next-cycle implication, checked out of reset
`define DOFP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("dofp check failed");

`endif

// ===== sv/dofp_pkg.sv =====
// shared types, widths and constants of the dual output fault protector
package dofp_pkg;

    localparam int TIME_W   = 32;
    localparam int VOLT_W   = 14;
    localparam int CUR_W    = 16;
    localparam int DIM_W    = 8;
    localparam int TARGET_W = 12;
    localparam int POWER_W  = CUR_W + VOLT_W;
    localparam int LIMIT_W  = TARGET_W + VOLT_W;
    localparam int COUNT_W  = 3;
    localparam int FAULT_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    localparam int SLOW_DELAY_MS_DEF = 1000;
    localparam int FAST_DELAY_MS_DEF = 200;
    localparam int HOLDOFF_MS_DEF    = 5000;
    localparam int TRIP_LIMIT_DEF    = 5;

    // watts above 110 percent of target, volts in tenths and current in mA
    localparam logic [VOLT_W-1:0] POWER_SCALE = 14'd11000;

    localparam logic [VOLT_W-1:0]   OVER_A_RST   = 14'd5500;
    localparam logic [VOLT_W-1:0]   UNDER_A_RST  = 14'd1500;
    localparam logic [VOLT_W-1:0]   SHORT_A_RST  = 14'd300;
    localparam logic [VOLT_W-1:0]   OVER_B_RST   = 14'd3000;
    localparam logic [VOLT_W-1:0]   UNDER_B_RST  = 14'd500;
    localparam logic [VOLT_W-1:0]   SHORT_B_RST  = 14'd200;
    localparam logic [TARGET_W-1:0] TARGET_A_RST = 12'd1200;
    localparam logic [TARGET_W-1:0] TARGET_B_RST = 12'd1200;

    localparam logic [CFG_IDX_W-1:0] REG_OVER_A   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_A  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_A  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_B   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_B  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_B  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 4'd7;

    localparam logic [1:0] CODE_NONE  = 2'd0;
    localparam logic [1:0] CODE_VOLT  = 2'd1;
    localparam logic [1:0] CODE_SHORT = 2'd2;
    localparam logic [1:0] CODE_POWER = 2'd3;

    localparam logic [FAULT_W-1:0] FAULT_B_BASE = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 3'd7;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_VOLT = 2'd1,
        KIND_FAST = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ACT_RUN      = 2'd0,
        ACT_SHUT_ALL = 2'd1,
        ACT_SHUT_A   = 2'd2,
        ACT_SHUT_B   = 2'd3
    } action_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] code;
    } class_t;

    typedef struct packed {
        logic [VOLT_W-1:0]  over_a;
        logic [VOLT_W-1:0]  under_a;
        logic [VOLT_W-1:0]  short_a;
        logic [VOLT_W-1:0]  over_b;
        logic [VOLT_W-1:0]  under_b;
        logic [VOLT_W-1:0]  short_b;
        logic [LIMIT_W-1:0] limit_a;
        logic [LIMIT_W-1:0] limit_b;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic              supply;
        logic              started;
        logic              upgrading;
        logic              thermal;
        logic              dims_zero;
        class_t            cls_a;
        class_t            cls_b;
    } item_t;

    typedef struct packed {
        kind_t              kind_a;
        kind_t              kind_b;
        logic [FAULT_W-1:0] last_fault;
        action_t            action;
        logic               restart;
        logic               locked;
    } result_t;

endpackage

// ===== sv/dofp_cfg_regs.sv =====
// configuration registers and registered power limits
module dofp_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [dofp_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [dofp_pkg::CFG_DATA_W-1:0]      wr_data,
    output dofp_pkg::cfg_t                       cfg
);

    logic [dofp_pkg::VOLT_W-1:0]   over_a_reg, under_a_reg, short_a_reg;
    logic [dofp_pkg::VOLT_W-1:0]   over_b_reg, under_b_reg, short_b_reg;
    logic [dofp_pkg::TARGET_W-1:0] target_a_reg, target_b_reg;
    logic [dofp_pkg::LIMIT_W-1:0]  limit_a_reg, limit_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_a_reg   <= dofp_pkg::OVER_A_RST;
            under_a_reg  <= dofp_pkg::UNDER_A_RST;
            short_a_reg  <= dofp_pkg::SHORT_A_RST;
            over_b_reg   <= dofp_pkg::OVER_B_RST;
            under_b_reg  <= dofp_pkg::UNDER_B_RST;
            short_b_reg  <= dofp_pkg::SHORT_B_RST;
            target_a_reg <= dofp_pkg::TARGET_A_RST;
            target_b_reg <= dofp_pkg::TARGET_B_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dofp_pkg::REG_OVER_A:   over_a_reg   <= wr_data;
                dofp_pkg::REG_UNDER_A:  under_a_reg  <= wr_data;
                dofp_pkg::REG_SHORT_A:  short_a_reg  <= wr_data;
                dofp_pkg::REG_OVER_B:   over_b_reg   <= wr_data;
                dofp_pkg::REG_UNDER_B:  under_b_reg  <= wr_data;
                dofp_pkg::REG_SHORT_B:  short_b_reg  <= wr_data;
                dofp_pkg::REG_TARGET_A: target_a_reg <= wr_data[dofp_pkg::TARGET_W-1:0];
                dofp_pkg::REG_TARGET_B: target_b_reg <= wr_data[dofp_pkg::TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // limits are registered from the targets and follow them in the next cycle, well inside the idle gap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_a_reg <= dofp_pkg::LIMIT_W'(dofp_pkg::TARGET_A_RST) *
                           dofp_pkg::LIMIT_W'(dofp_pkg::POWER_SCALE);
            limit_b_reg <= dofp_pkg::LIMIT_W'(dofp_pkg::TARGET_B_RST) *
                           dofp_pkg::LIMIT_W'(dofp_pkg::POWER_SCALE);
        end
        else
        begin
            limit_a_reg <= dofp_pkg::LIMIT_W'(target_a_reg) *
                           dofp_pkg::LIMIT_W'(dofp_pkg::POWER_SCALE);
            limit_b_reg <= dofp_pkg::LIMIT_W'(target_b_reg) *
                           dofp_pkg::LIMIT_W'(dofp_pkg::POWER_SCALE);
        end
    end

    assign cfg.over_a  = over_a_reg;
    assign cfg.under_a = under_a_reg;
    assign cfg.short_a = short_a_reg;
    assign cfg.over_b  = over_b_reg;
    assign cfg.under_b = under_b_reg;
    assign cfg.short_b = short_b_reg;
    assign cfg.limit_a = limit_a_reg;
    assign cfg.limit_b = limit_b_reg;

endmodule

// ===== sv/dofp_classify.sv =====
// per-channel fault classification of one measurement
module dofp_classify
(
    input  logic [dofp_pkg::DIM_W-1:0]   dim,
    input  logic [dofp_pkg::VOLT_W-1:0]  volt,
    input  logic [dofp_pkg::CUR_W-1:0]   cur,
    input  logic [dofp_pkg::VOLT_W-1:0]  over,
    input  logic [dofp_pkg::VOLT_W-1:0]  under,
    input  logic [dofp_pkg::VOLT_W-1:0]  shrt,
    input  logic [dofp_pkg::LIMIT_W-1:0] limit,
    output dofp_pkg::class_t             cls
);

    logic [dofp_pkg::POWER_W-1:0] power;

    assign power = dofp_pkg::POWER_W'(cur) * dofp_pkg::POWER_W'(volt);

    always_comb
    begin
        cls.kind = dofp_pkg::KIND_NONE;
        cls.code = dofp_pkg::CODE_NONE;
        // levels 0 and 1 count as off
        if (dim > 8'd1)
        begin
            if (volt >= over || volt <= under)
            begin
                cls.kind = dofp_pkg::KIND_VOLT;
                cls.code = dofp_pkg::CODE_VOLT;
            end
            else if (volt <= shrt)
            begin
                cls.kind = dofp_pkg::KIND_FAST;
                cls.code = dofp_pkg::CODE_SHORT;
            end
            else if (power > dofp_pkg::POWER_W'(limit))
            begin
                cls.kind = dofp_pkg::KIND_FAST;
                cls.code = dofp_pkg::CODE_POWER;
            end
        end
    end

endmodule

// ===== sv/dofp_state.sv =====
// persistence timers, hold-off, lock-out and shutdown decision
module dofp_state
#(
    parameter int SLOW_DELAY_MS = dofp_pkg::SLOW_DELAY_MS_DEF,
    parameter int FAST_DELAY_MS = dofp_pkg::FAST_DELAY_MS_DEF,
    parameter int HOLDOFF_MS    = dofp_pkg::HOLDOFF_MS_DEF,
    parameter int TRIP_LIMIT    = dofp_pkg::TRIP_LIMIT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dofp_pkg::item_t   item,
    output dofp_pkg::result_t result
);

    localparam logic [dofp_pkg::TIME_W-1:0]  SLOW_LIM = dofp_pkg::TIME_W'(SLOW_DELAY_MS);
    localparam logic [dofp_pkg::TIME_W-1:0]  FAST_LIM = dofp_pkg::TIME_W'(FAST_DELAY_MS);
    localparam logic [dofp_pkg::TIME_W-1:0]  HOLD_LIM = dofp_pkg::TIME_W'(HOLDOFF_MS);
    localparam logic [dofp_pkg::COUNT_W-1:0] LOCK_CNT = dofp_pkg::COUNT_W'(TRIP_LIMIT);

    logic [dofp_pkg::TIME_W-1:0]  start_a_reg, start_a_next;
    logic [dofp_pkg::TIME_W-1:0]  start_b_reg, start_b_next;
    logic                         slow_a_reg, slow_a_next, fast_a_reg, fast_a_next;
    logic                         slow_b_reg, slow_b_next, fast_b_reg, fast_b_next;
    logic                         holdoff_reg, holdoff_next;
    logic                         latched_reg, latched_next;
    logic [dofp_pkg::COUNT_W-1:0] count_reg, count_next;
    dofp_pkg::kind_t              kind_a_reg, kind_a_next, kind_b_reg, kind_b_next;
    logic [dofp_pkg::FAULT_W-1:0] fault_reg, fault_next;

    logic                         go;
    logic                         restart;
    logic [dofp_pkg::TIME_W-1:0]  el_a, el_b;
    logic [dofp_pkg::COUNT_W-1:0] count_inc;

    assign go        = item.supply && item.started;
    assign el_a      = item.now - start_a_reg;
    assign el_b      = item.now - start_b_reg;
    assign count_inc = (count_reg < dofp_pkg::COUNT_MAX) ? count_reg + 3'd1 : count_reg;

    always_comb
    begin
        start_a_next = start_a_reg;
        start_b_next = start_b_reg;
        slow_a_next  = slow_a_reg;
        fast_a_next  = fast_a_reg;
        slow_b_next  = slow_b_reg;
        fast_b_next  = fast_b_reg;
        holdoff_next = holdoff_reg;
        latched_next = latched_reg;
        count_next   = count_reg;
        kind_a_next  = kind_a_reg;
        kind_b_next  = kind_b_reg;
        fault_next   = fault_reg;
        restart      = 1'b0;

        if (go)
        begin
            // channel 2 takes priority, so its fault wins when both channels report one
            if (item.cls_b.code != dofp_pkg::CODE_NONE)
                fault_next = dofp_pkg::FAULT_W'(item.cls_b.code) + dofp_pkg::FAULT_B_BASE;
            else if (item.cls_a.code != dofp_pkg::CODE_NONE)
                fault_next = dofp_pkg::FAULT_W'(item.cls_a.code);

            if (holdoff_reg)
            begin
                if (el_a >= HOLD_LIM)
                begin
                    holdoff_next = 1'b0;
                    kind_a_next  = dofp_pkg::KIND_NONE;
                    restart      = 1'b1;
                end
            end
            else if (latched_reg)
                kind_a_next = dofp_pkg::KIND_VOLT;
            else if (item.cls_a.kind == dofp_pkg::KIND_VOLT)
            begin
                if (!slow_a_reg)
                begin
                    start_a_next = item.now;
                    slow_a_next  = 1'b1;
                end
                else if (el_a > SLOW_LIM)
                begin
                    kind_a_next  = dofp_pkg::KIND_VOLT;
                    holdoff_next = 1'b1;
                    start_a_next = item.now;
                    slow_a_next  = 1'b0;
                    count_next   = count_inc;
                    if (count_inc >= LOCK_CNT)
                        latched_next = 1'b1;
                end
            end
            else if (item.cls_a.kind == dofp_pkg::KIND_FAST)
            begin
                if (!fast_a_reg)
                begin
                    start_a_next = item.now;
                    fast_a_next  = 1'b1;
                end
                else if (el_a > FAST_LIM)
                begin
                    kind_a_next = dofp_pkg::KIND_FAST;
                    fast_a_next = 1'b0;
                end
            end
            else
            begin
                kind_a_next = dofp_pkg::KIND_NONE;
                slow_a_next = 1'b0;
                fast_a_next = 1'b0;
            end

            if (item.cls_b.kind == dofp_pkg::KIND_VOLT)
            begin
                if (!slow_b_reg)
                begin
                    start_b_next = item.now;
                    slow_b_next  = 1'b1;
                end
                else if (el_b > SLOW_LIM)
                begin
                    kind_b_next = dofp_pkg::KIND_VOLT;
                    slow_b_next = 1'b0;
                end
            end
            else if (item.cls_b.kind == dofp_pkg::KIND_FAST)
            begin
                if (!fast_b_reg)
                begin
                    start_b_next = item.now;
                    fast_b_next  = 1'b1;
                end
                else if (el_b > FAST_LIM)
                begin
                    kind_b_next = dofp_pkg::KIND_FAST;
                    fast_b_next = 1'b0;
                end
            end
            else
            begin
                kind_b_next = dofp_pkg::KIND_NONE;
                slow_b_next = 1'b0;
                fast_b_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_a_reg <= '0;
            start_b_reg <= '0;
            slow_a_reg  <= 1'b0;
            fast_a_reg  <= 1'b0;
            slow_b_reg  <= 1'b0;
            fast_b_reg  <= 1'b0;
            holdoff_reg <= 1'b0;
            latched_reg <= 1'b0;
            count_reg   <= '0;
            kind_a_reg  <= dofp_pkg::KIND_NONE;
            kind_b_reg  <= dofp_pkg::KIND_NONE;
            fault_reg   <= '0;
        end
        else if (advance)
        begin
            start_a_reg <= start_a_next;
            start_b_reg <= start_b_next;
            slow_a_reg  <= slow_a_next;
            fast_a_reg  <= fast_a_next;
            slow_b_reg  <= slow_b_next;
            fast_b_reg  <= fast_b_next;
            holdoff_reg <= holdoff_next;
            latched_reg <= latched_next;
            count_reg   <= count_next;
            kind_a_reg  <= kind_a_next;
            kind_b_reg  <= kind_b_next;
            fault_reg   <= fault_next;
        end
    end

    always_comb
    begin
        result.kind_a     = kind_a_next;
        result.kind_b     = kind_b_next;
        result.last_fault = fault_next;
        result.restart    = restart;
        result.locked     = latched_next;
        if (!item.supply || item.upgrading || item.thermal || item.dims_zero)
            result.action = dofp_pkg::ACT_SHUT_ALL;
        else if (kind_a_next != dofp_pkg::KIND_NONE && kind_b_next != dofp_pkg::KIND_NONE)
            result.action = dofp_pkg::ACT_SHUT_ALL;
        else if (kind_a_next != dofp_pkg::KIND_NONE)
            result.action = dofp_pkg::ACT_SHUT_A;
        else if (kind_b_next != dofp_pkg::KIND_NONE)
            result.action = dofp_pkg::ACT_SHUT_B;
        else
            result.action = dofp_pkg::ACT_RUN;
    end

endmodule

// ===== sv/dual_output_fault_protector.sv =====
// top level of the two-channel led output fault protector
// Takes one protection tick per clock and returns one result per tick. An item
// goes through three registers: the input register, the classification
// register (window compares and the current-times-voltage multiply against
// the power limit) and the result register (persistence timers, hold-off,
// lock-out and shutdown choice), and its result is read from the result
// register. With out_ready held high a new item is taken every cycle; a
// stalled output holds the pipeline, and in_ready falls once all three
// stages are full. Configuration writes are always taken and reach the
// power limits through the target registers, which feed the limit registers.
`include "dual_output_fault_protector_defines.svh"

module dual_output_fault_protector
#(
    parameter int SLOW_DELAY_MS = dofp_pkg::SLOW_DELAY_MS_DEF,
    parameter int FAST_DELAY_MS = dofp_pkg::FAST_DELAY_MS_DEF,
    parameter int HOLDOFF_MS    = dofp_pkg::HOLDOFF_MS_DEF,
    parameter int TRIP_LIMIT    = dofp_pkg::TRIP_LIMIT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dofp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dofp_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dofp_pkg::TIME_W-1:0]      now_ms,
    input  logic                             supply_ok,
    input  logic                             outputs_started,
    input  logic                             upgrading,
    input  logic                             thermal_shutdown,
    input  logic [dofp_pkg::DIM_W-1:0]       dim_level_a,
    input  logic [dofp_pkg::DIM_W-1:0]       dim_level_b,
    input  logic [dofp_pkg::VOLT_W-1:0]      volt_a,
    input  logic [dofp_pkg::VOLT_W-1:0]      volt_b,
    input  logic [dofp_pkg::CUR_W-1:0]       current_a,
    input  logic [dofp_pkg::CUR_W-1:0]       current_b,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       trip_kind_a,
    output logic [1:0]                       trip_kind_b,
    output logic [dofp_pkg::FAULT_W-1:0]     last_fault,
    output logic [1:0]                       shutdown_action,
    output logic                             restart_a,
    output logic                             locked_a
);

    dofp_pkg::cfg_t    cfg;
    dofp_pkg::class_t  cls_a, cls_b;
    dofp_pkg::item_t   item_reg, item_next;
    dofp_pkg::result_t result, result_reg;

    logic                           s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [dofp_pkg::TIME_W-1:0]    now_reg;
    logic                           supply_reg, started_reg, upgrading_reg, thermal_reg;
    logic [dofp_pkg::DIM_W-1:0]     dim_a_reg, dim_b_reg;
    logic [dofp_pkg::VOLT_W-1:0]    volt_a_reg, volt_b_reg;
    logic [dofp_pkg::CUR_W-1:0]     cur_a_reg, cur_b_reg;

    logic in_take, s1_move, s2_ready, out_load;

    assign cfg_ready = 1'b1;

    dofp_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // pipeline handshake, back-pressure runs from the output to the input
    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_ready = !s2_valid_reg || out_load;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (out_load)
                s2_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg       <= now_ms;
            supply_reg    <= supply_ok;
            started_reg   <= outputs_started;
            upgrading_reg <= upgrading;
            thermal_reg   <= thermal_shutdown;
            dim_a_reg     <= dim_level_a;
            dim_b_reg     <= dim_level_b;
            volt_a_reg    <= volt_a;
            volt_b_reg    <= volt_b;
            cur_a_reg     <= current_a;
            cur_b_reg     <= current_b;
        end
    end

    dofp_classify u_cls_a
    (
        .dim   (dim_a_reg),
        .volt  (volt_a_reg),
        .cur   (cur_a_reg),
        .over  (cfg.over_a),
        .under (cfg.under_a),
        .shrt  (cfg.short_a),
        .limit (cfg.limit_a),
        .cls   (cls_a)
    );

    dofp_classify u_cls_b
    (
        .dim   (dim_b_reg),
        .volt  (volt_b_reg),
        .cur   (cur_b_reg),
        .over  (cfg.over_b),
        .under (cfg.under_b),
        .shrt  (cfg.short_b),
        .limit (cfg.limit_b),
        .cls   (cls_b)
    );

    always_comb
    begin
        item_next.now       = now_reg;
        item_next.supply    = supply_reg;
        item_next.started   = started_reg;
        item_next.upgrading = upgrading_reg;
        item_next.thermal   = thermal_reg;
        item_next.dims_zero = (dim_a_reg == '0) && (dim_b_reg == '0);
        item_next.cls_a     = cls_a;
        item_next.cls_b     = cls_b;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            item_reg <= item_next;
    end

    dofp_state
    #(
        .SLOW_DELAY_MS (SLOW_DELAY_MS),
        .FAST_DELAY_MS (FAST_DELAY_MS),
        .HOLDOFF_MS    (HOLDOFF_MS),
        .TRIP_LIMIT    (TRIP_LIMIT)
    )
    u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (out_load),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
            result_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign trip_kind_a     = result_reg.kind_a;
    assign trip_kind_b     = result_reg.kind_b;
    assign last_fault      = result_reg.last_fault;
    assign shutdown_action = result_reg.action;
    assign restart_a       = result_reg.restart;
    assign locked_a        = result_reg.locked;

    // restart ends a hold-off, which clears the channel 1 trip
    `DOFP_ASSERT_NOW(a_restart_clears, clk, rst_n, out_valid && restart_a, trip_kind_a == dofp_pkg::KIND_NONE)
    // two tripped channels always shut both outputs
    `DOFP_ASSERT_NOW(a_both_shut, clk, rst_n, out_valid && trip_kind_a != dofp_pkg::KIND_NONE && trip_kind_b != dofp_pkg::KIND_NONE, shutdown_action == dofp_pkg::ACT_SHUT_ALL)
    // the lock-out never releases
    `DOFP_ASSERT_NEXT(a_lock_sticky, clk, rst_n, out_valid && locked_a, locked_a)
    // a waiting result is not overwritten
    `DOFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(result_reg))

endmodule

// ===== test/dofp_checker.sv =====
// checker for the dual output fault protector: trip predictor and result compare
module dofp_checker
    import dofp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  supply_ok,
    input  logic                  outputs_started,
    input  logic                  upgrading,
    input  logic                  thermal_shutdown,
    input  logic [DIM_W-1:0]      dim_level_a,
    input  logic [DIM_W-1:0]      dim_level_b,
    input  logic [VOLT_W-1:0]     volt_a,
    input  logic [VOLT_W-1:0]     volt_b,
    input  logic [CUR_W-1:0]      current_a,
    input  logic [CUR_W-1:0]      current_b,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            trip_kind_a,
    input  logic [1:0]            trip_kind_b,
    input  logic [FAULT_W-1:0]    last_fault,
    input  logic [1:0]            shutdown_action,
    input  logic                  restart_a,
    input  logic                  locked_a,
    output int unsigned           mismatches,
    output int unsigned           awaiting
);

    localparam logic [FAULT_W-1:0] FAULT_A_BASE = 3'd0;

    logic [VOLT_W-1:0]  limits [0:15];
    logic [TIME_W-1:0]  stamp_a;
    logic [TIME_W-1:0]  stamp_b;
    logic               slow_wait_a;
    logic               fast_wait_a;
    logic               slow_wait_b;
    logic               fast_wait_b;
    logic               holdoff_q;
    logic               lock_q;
    logic [COUNT_W-1:0] slow_trips;
    kind_t              kind_a_q;
    kind_t              kind_b_q;
    logic [FAULT_W-1:0] fault_q;
    result_t            trip_verdicts [$];

    // window, short and power compares; a judged fault also moves the sticky code
    function automatic kind_t judge(input logic [DIM_W-1:0] dim, input logic [VOLT_W-1:0] v,
                                    input logic [CUR_W-1:0] i,
                                    input logic [CFG_IDX_W-1:0] reg_over,
                                    input logic [CFG_IDX_W-1:0] reg_under,
                                    input logic [CFG_IDX_W-1:0] reg_short,
                                    input logic [CFG_IDX_W-1:0] reg_target,
                                    input logic [FAULT_W-1:0] base);
        if (dim <= 8'd1)
            return KIND_NONE;
        if (v >= limits[reg_over] || v <= limits[reg_under])
        begin
            fault_q = base + {1'b0, CODE_VOLT};
            return KIND_VOLT;
        end
        if (v <= limits[reg_short])
        begin
            fault_q = base + {1'b0, CODE_SHORT};
            return KIND_FAST;
        end
        if (64'(i) * 64'(v) > 64'(limits[reg_target]) * 64'(POWER_SCALE))
        begin
            fault_q = base + {1'b0, CODE_POWER};
            return KIND_FAST;
        end
        return KIND_NONE;
    endfunction

    task automatic predict_tick();
        logic [TIME_W-1:0] el_a;
        logic [TIME_W-1:0] el_b;
        kind_t             ka;
        kind_t             kb;
        result_t           r;
        r.restart = 1'b0;
        if (supply_ok && outputs_started)
        begin
            el_a = now_ms - stamp_a;
            el_b = now_ms - stamp_b;
            ka = judge(dim_level_a, volt_a, current_a, REG_OVER_A, REG_UNDER_A, REG_SHORT_A,
                       REG_TARGET_A, FAULT_A_BASE);
            if (holdoff_q)
            begin
                if (el_a >= HOLDOFF_MS_DEF)
                begin
                    holdoff_q = 1'b0;
                    kind_a_q  = KIND_NONE;
                    r.restart = 1'b1;
                end
            end
            else if (lock_q)
                kind_a_q = KIND_VOLT;
            else if (ka == KIND_VOLT)
            begin
                if (!slow_wait_a)
                begin
                    stamp_a     = now_ms;
                    slow_wait_a = 1'b1;
                end
                else if (el_a > SLOW_DELAY_MS_DEF)
                begin
                    kind_a_q    = KIND_VOLT;
                    holdoff_q   = 1'b1;
                    stamp_a     = now_ms;
                    slow_wait_a = 1'b0;
                    if (slow_trips < COUNT_MAX)
                        slow_trips++;
                    if (slow_trips >= TRIP_LIMIT_DEF)
                        lock_q = 1'b1;
                end
            end
            else if (ka == KIND_FAST)
            begin
                if (!fast_wait_a)
                begin
                    stamp_a     = now_ms;
                    fast_wait_a = 1'b1;
                end
                else if (el_a > FAST_DELAY_MS_DEF)
                begin
                    kind_a_q    = KIND_FAST;
                    fast_wait_a = 1'b0;
                end
            end
            else
            begin
                kind_a_q    = KIND_NONE;
                slow_wait_a = 1'b0;
                fast_wait_a = 1'b0;
            end

            kb = judge(dim_level_b, volt_b, current_b, REG_OVER_B, REG_UNDER_B, REG_SHORT_B,
                       REG_TARGET_B, FAULT_B_BASE);
            if (kb == KIND_VOLT)
            begin
                if (!slow_wait_b)
                begin
                    stamp_b     = now_ms;
                    slow_wait_b = 1'b1;
                end
                else if (el_b > SLOW_DELAY_MS_DEF)
                begin
                    kind_b_q    = KIND_VOLT;
                    slow_wait_b = 1'b0;
                end
            end
            else if (kb == KIND_FAST)
            begin
                if (!fast_wait_b)
                begin
                    stamp_b     = now_ms;
                    fast_wait_b = 1'b1;
                end
                else if (el_b > FAST_DELAY_MS_DEF)
                begin
                    kind_b_q    = KIND_FAST;
                    fast_wait_b = 1'b0;
                end
            end
            else
            begin
                kind_b_q    = KIND_NONE;
                slow_wait_b = 1'b0;
                fast_wait_b = 1'b0;
            end
        end

        if (!supply_ok || upgrading || thermal_shutdown
            || (dim_level_a == '0 && dim_level_b == '0))
            r.action = ACT_SHUT_ALL;
        else if (kind_a_q != KIND_NONE && kind_b_q != KIND_NONE)
            r.action = ACT_SHUT_ALL;
        else if (kind_a_q != KIND_NONE)
            r.action = ACT_SHUT_A;
        else if (kind_b_q != KIND_NONE)
            r.action = ACT_SHUT_B;
        else
            r.action = ACT_RUN;

        r.kind_a     = kind_a_q;
        r.kind_b     = kind_b_q;
        r.last_fault = fault_q;
        r.locked     = lock_q;
        trip_verdicts.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [2:0] want, input logic [2:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t head;
        if (!rst_n)
        begin
            limits[REG_OVER_A]   = OVER_A_RST;
            limits[REG_UNDER_A]  = UNDER_A_RST;
            limits[REG_SHORT_A]  = SHORT_A_RST;
            limits[REG_OVER_B]   = OVER_B_RST;
            limits[REG_UNDER_B]  = UNDER_B_RST;
            limits[REG_SHORT_B]  = SHORT_B_RST;
            limits[REG_TARGET_A] = {2'b00, TARGET_A_RST};
            limits[REG_TARGET_B] = {2'b00, TARGET_B_RST};
            stamp_a     = '0;
            stamp_b     = '0;
            slow_wait_a = 1'b0;
            fast_wait_a = 1'b0;
            slow_wait_b = 1'b0;
            fast_wait_b = 1'b0;
            holdoff_q   = 1'b0;
            lock_q      = 1'b0;
            slow_trips  = '0;
            kind_a_q    = KIND_NONE;
            kind_b_q    = KIND_NONE;
            fault_q     = '0;
            trip_verdicts.delete();
            mismatches  = 0;
        end
        else
        begin
            // indexes past the last register are dropped, targets keep 12 bits
            if (cfg_valid && cfg_ready && cfg_index <= REG_TARGET_B)
                limits[cfg_index] = (cfg_index >= REG_TARGET_A)
                                    ? {2'b00, cfg_data[TARGET_W-1:0]} : cfg_data;
            if (out_valid && out_ready)
            begin
                if (trip_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with nothing expected", $time);
                end
                else
                begin
                    head = trip_verdicts.pop_front();
                    check_field("trip_kind_a", head.kind_a, trip_kind_a);
                    check_field("trip_kind_b", head.kind_b, trip_kind_b);
                    check_field("last_fault", head.last_fault, last_fault);
                    check_field("shutdown_action", head.action, shutdown_action);
                    check_field("restart_a", head.restart, restart_a);
                    check_field("locked_a", head.locked, locked_a);
                end
            end
            if (in_valid && in_ready)
                predict_tick();
        end
        awaiting = trip_verdicts.size();
    end

endmodule

// ===== test/tb_dual_output_fault_protector.sv =====
// testbench top for the dual output fault protector: stimulus, idling and verdict
module tb_dual_output_fault_protector;
    import dofp_pkg::*;

    localparam int WATCHDOG_UNITS = 2_000_000;
    localparam int PHASES         = 6;
    localparam int VOLT_MAX       = 10000;
    localparam int CUR_MAX        = 65535;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

    typedef enum int { CH_OFF, CH_HEALTHY, CH_SLOW, CH_SHORT, CH_POWER, CH_NOISE } ch_mode_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              supply;
        logic              started;
        logic              upgrade;
        logic              thermal;
        logic [DIM_W-1:0]  dim_a;
        logic [DIM_W-1:0]  dim_b;
        logic [VOLT_W-1:0] volt_a;
        logic [VOLT_W-1:0] volt_b;
        logic [CUR_W-1:0]  cur_a;
        logic [CUR_W-1:0]  cur_b;
    } tick_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [TIME_W-1:0]     now_ms;
    logic                  supply_ok;
    logic                  outputs_started;
    logic                  upgrading;
    logic                  thermal_shutdown;
    logic [DIM_W-1:0]      dim_level_a;
    logic [DIM_W-1:0]      dim_level_b;
    logic [VOLT_W-1:0]     volt_a;
    logic [VOLT_W-1:0]     volt_b;
    logic [CUR_W-1:0]      current_a;
    logic [CUR_W-1:0]      current_b;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            trip_kind_a;
    logic [1:0]            trip_kind_b;
    logic [FAULT_W-1:0]    last_fault;
    logic [1:0]            shutdown_action;
    logic                  restart_a;
    logic                  locked_a;
    int unsigned           mismatches;
    int unsigned           awaiting;

    bit                    calm;
    int                    shadow [0:15];
    logic [TIME_W-1:0]     tick_ms;

    dual_output_fault_protector u_top (.*);

    dofp_checker u_check (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #(WATCHDOG_UNITS);
        $display("TEST FAILED");
        $finish;
    end

    // result side stalls in bursts, with quiet stretches between
    initial
    begin
        out_ready = 1'b1;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(10, 40)) @(negedge clk);
        end
    end

    task automatic send_tick(input tick_t t);
        @(negedge clk);
        in_valid         <= 1'b1;
        now_ms           <= t.stamp;
        supply_ok        <= t.supply;
        outputs_started  <= t.started;
        upgrading        <= t.upgrade;
        thermal_shutdown <= t.thermal;
        dim_level_a      <= t.dim_a;
        dim_level_b      <= t.dim_b;
        volt_a           <= t.volt_a;
        volt_b           <= t.volt_b;
        current_a        <= t.cur_a;
        current_b        <= t.cur_b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic pause(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // hold the sender until every result item is back, then idle on before returning
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx <= REG_TARGET_B)
            shadow[idx] = (idx >= REG_TARGET_A) ? (value & 12'hFFF) : (value & 14'h3FFF);
    endtask

    task automatic set_limits(input int over_a, input int under_a, input int short_a,
                              input int over_b, input int under_b, input int short_b,
                              input int target_a, input int target_b);
        write_reg(REG_OVER_A, over_a);
        write_reg(REG_UNDER_A, under_a);
        write_reg(REG_SHORT_A, short_a);
        write_reg(REG_OVER_B, over_b);
        write_reg(REG_UNDER_B, under_b);
        write_reg(REG_SHORT_B, short_b);
        write_reg(REG_TARGET_A, target_a);
        write_reg(REG_TARGET_B, target_b);
        repeat (2) @(negedge clk);
    endtask

    function automatic tick_t live_tick(input logic [TIME_W-1:0] at);
        tick_t t;
        t = '0;
        t.stamp   = at;
        t.supply  = 1'b1;
        t.started = 1'b1;
        t.dim_a   = 8'd2;
        t.dim_b   = 8'd2;
        return t;
    endfunction

    function automatic ch_mode_t pick_mode(input int slow_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < slow_weight)
            return CH_SLOW;
        if (r < slow_weight + 10)
            return CH_OFF;
        if (r < slow_weight + 25)
            return CH_SHORT;
        if (r < slow_weight + 40)
            return CH_POWER;
        if (r < slow_weight + 50)
            return CH_NOISE;
        return CH_HEALTHY;
    endfunction

    // voltage and current aimed at the chosen mode (off, healthy, one class of fault or noise) under the current limits
    task automatic shape_channel(input ch_mode_t mode, input int over, input int under,
                                 input int shrt, input int target,
                                 output logic [DIM_W-1:0] dim, output logic [VOLT_W-1:0] v,
                                 output logic [CUR_W-1:0] i);
        int     lo;
        int     hi;
        int     vv;
        longint lim;
        longint edge_i;
        dim = DIM_W'($urandom_range(2, 255));
        v   = VOLT_W'($urandom_range(0, VOLT_MAX));
        i   = CUR_W'($urandom_range(0, CUR_MAX));
        lo  = ((under > shrt) ? under : shrt) + 1;
        hi  = over - 1;
        lim = longint'(target) * longint'(POWER_SCALE);
        case (mode)
            CH_OFF:
                dim = DIM_W'($urandom_range(0, 1));
            CH_SLOW:
            begin
                if ($urandom_range(0, 1) == 0 && over <= VOLT_MAX)
                    v = VOLT_W'(($urandom_range(0, 3) == 0) ? over
                                : $urandom_range(over, VOLT_MAX));
                else
                    v = VOLT_W'(($urandom_range(0, 3) == 0) ? under
                                : $urandom_range(0, under));
            end
            CH_SHORT:
            begin
                hi = (shrt < over - 1) ? shrt : over - 1;
                if (under + 1 <= hi)
                    v = VOLT_W'(($urandom_range(0, 3) == 0) ? hi
                                : $urandom_range(under + 1, hi));
            end
            CH_HEALTHY, CH_POWER:
            begin
                if (lo <= hi && hi <= VOLT_MAX)
                begin
                    vv = $urandom_range(lo, hi);
                    v  = VOLT_W'(vv);
                    edge_i = lim / vv;
                    if (mode == CH_HEALTHY)
                    begin
                        if (edge_i > CUR_MAX)
                            edge_i = CUR_MAX;
                        i = CUR_W'(($urandom_range(0, 3) == 0) ? edge_i
                                   : $urandom_range(0, int'(edge_i)));
                    end
                    else if (edge_i + 1 <= CUR_MAX)
                        i = CUR_W'(($urandom_range(0, 3) == 0) ? edge_i + 1
                                   : $urandom_range(int'(edge_i) + 1, CUR_MAX));
                    else
                        i = CUR_W'(CUR_MAX);
                end
            end
            default:
                ;
        endcase
    endtask

    initial
    begin
        tick_t    t;
        ch_mode_t mode_a;
        ch_mode_t mode_b;
        int       run_a;
        int       run_b;
        int       n_items;
        int       r;

        rst_n            = 1'b0;
        calm             = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        now_ms           = '0;
        supply_ok        = 1'b0;
        outputs_started  = 1'b0;
        upgrading        = 1'b0;
        thermal_shutdown = 1'b0;
        dim_level_a      = '0;
        dim_level_b      = '0;
        volt_a           = '0;
        volt_b           = '0;
        current_a        = '0;
        current_b        = '0;
        shadow[REG_OVER_A]   = OVER_A_RST;
        shadow[REG_UNDER_A]  = UNDER_A_RST;
        shadow[REG_SHORT_A]  = SHORT_A_RST;
        shadow[REG_OVER_B]   = OVER_B_RST;
        shadow[REG_UNDER_B]  = UNDER_B_RST;
        shadow[REG_SHORT_B]  = SHORT_B_RST;
        shadow[REG_TARGET_A] = TARGET_A_RST;
        shadow[REG_TARGET_B] = TARGET_B_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // supply down with everything at zero
        t = '0;
        send_tick(t);
        // outputs not started, fields at their top values, upgrade in progress
        t.supply  = 1'b1;
        t.upgrade = 1'b1;
        t.stamp   = 1;
        t.dim_a   = '1;
        t.dim_b   = '1;
        t.volt_a  = VOLT_W'(VOLT_MAX);
        t.volt_b  = VOLT_W'(VOLT_MAX);
        t.cur_a   = '1;
        t.cur_b   = '1;
        send_tick(t);
        t = live_tick(2);
        t.dim_a   = '0;
        t.dim_b   = '0;
        t.thermal = 1'b1;
        send_tick(t);
        // dim level one is never judged
        t = live_tick(3);
        t.dim_a  = 8'd1;
        t.dim_b  = 8'd1;
        t.volt_a = VOLT_W'(VOLT_MAX);
        send_tick(t);
        // exactly at 110 percent of target, then one milliampere over
        t = live_tick(4);
        t.volt_a = 14'd2000;
        t.cur_a  = 16'd6600;
        t.volt_b = 14'd1000;
        t.cur_b  = 16'd13200;
        send_tick(t);
        t.stamp = 5;
        t.cur_a = 16'd6601;
        t.cur_b = 16'd13201;
        send_tick(t);
        // window edges
        t = live_tick(6);
        t.volt_a = 14'd5500;
        t.volt_b = 14'd3000;
        send_tick(t);
        t = live_tick(7);
        t.volt_a = 14'd1500;
        t.volt_b = 14'd500;
        send_tick(t);
        t = live_tick(8);
        t.volt_a = 14'd5499;
        t.volt_b = 14'd2999;
        send_tick(t);
        t = live_tick('1);
        t.dim_a = '1;
        t.cur_a = '1;
        send_tick(t);
        t = live_tick(0);
        t.dim_b  = '1;
        t.volt_a = VOLT_W'(VOLT_MAX);
        t.volt_b = VOLT_W'(VOLT_MAX);
        t.cur_a  = '1;
        t.cur_b  = '1;
        send_tick(t);

        // open a gap between under and short limits, zero targets
        drain();
        set_limits(5500, 100, 300, 3000, 50, 200, 0, 0);
        t = live_tick(20);
        t.volt_a = 14'd300;
        t.volt_b = 14'd200;
        send_tick(t);
        t = live_tick(21);
        t.volt_a = 14'd101;
        t.volt_b = 14'd51;
        send_tick(t);
        t = live_tick(22);
        t.volt_a = 14'd301;
        t.cur_a  = 16'd1;
        t.volt_b = 14'd201;
        send_tick(t);
        t = live_tick(23);
        t.volt_a = 14'd1000;
        t.volt_b = 14'd1000;
        send_tick(t);
        // overvoltage held just past the slow delay, then the hold-off runs out
        t = live_tick(100);
        t.volt_a = 14'd6000;
        t.volt_b = 14'd6000;
        send_tick(t);
        t.stamp = 1100;
        send_tick(t);
        t.stamp = 1101;
        send_tick(t);
        t.stamp = 6100;
        send_tick(t);
        t.stamp = 6101;
        send_tick(t);

        tick_ms = 32'd10000;
        run_a   = 0;
        run_b   = 0;
        mode_a  = CH_HEALTHY;
        mode_b  = CH_HEALTHY;
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(REG_UNUSED, $urandom_range(0, 16383));
                    set_limits($urandom_range(2000, VOLT_MAX), $urandom_range(0, 2500),
                               $urandom_range(0, 1500), $urandom_range(2000, VOLT_MAX),
                               $urandom_range(0, 2500), $urandom_range(0, 1500),
                               $urandom_range(0, 4000), $urandom_range(0, 4000));
                end
                1: set_limits(0, 0, 0, 0, 0, 0, 0, 0);
                2: set_limits(VOLT_MAX, 0, 0, VOLT_MAX, 0, 0, 4000, 16383);
                5: set_limits(OVER_A_RST, UNDER_A_RST, SHORT_A_RST, OVER_B_RST,
                              UNDER_B_RST, SHORT_B_RST, TARGET_A_RST, TARGET_B_RST);
                default:
                    set_limits($urandom_range(2000, VOLT_MAX), $urandom_range(0, 2500),
                               $urandom_range(0, 1500), $urandom_range(2000, VOLT_MAX),
                               $urandom_range(0, 2500), $urandom_range(0, 1500),
                               $urandom_range(0, 4000), $urandom_range(0, 4000));
            endcase
            if (p == 3)
                tick_ms = 32'hFFFF_F000;
            calm    = (p == PHASES - 1);
            n_items = (p == 1) ? 40 : 142;
            for (int n = 0; n < n_items; n++)
            begin
                if (p == 0 && n == 70)
                    drain();
                if (!calm && $urandom_range(0, 5) == 0)
                    pause($urandom_range(1, 9));
                if (run_a == 0)
                begin
                    mode_a = pick_mode(calm ? 40 : 6);
                    run_a  = $urandom_range(1, 25);
                end
                if (run_b == 0)
                begin
                    mode_b = pick_mode(20);
                    run_b  = $urandom_range(1, 25);
                end
                run_a--;
                run_b--;
                // mostly ordinary tick spacing, now and then a repeat or a wild jump
                r = $urandom_range(0, 99);
                if (r < 3)
                    ;
                else if (r < 5)
                    tick_ms += $urandom;
                else
                    tick_ms += $urandom_range(1, 400);
                t = '0;
                t.stamp   = tick_ms;
                t.supply  = ($urandom_range(0, 39) != 0);
                t.started = ($urandom_range(0, 29) != 0);
                t.upgrade = ($urandom_range(0, 49) == 0);
                t.thermal = ($urandom_range(0, 49) == 0);
                shape_channel(mode_a, shadow[REG_OVER_A], shadow[REG_UNDER_A],
                              shadow[REG_SHORT_A], shadow[REG_TARGET_A],
                              t.dim_a, t.volt_a, t.cur_a);
                shape_channel(mode_b, shadow[REG_OVER_B], shadow[REG_UNDER_B],
                              shadow[REG_SHORT_B], shadow[REG_TARGET_B],
                              t.dim_b, t.volt_b, t.cur_b);
                send_tick(t);
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
